>>> hdl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared constants and types of the program map section parser.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int MAX_STREAMS = 16;
  // count must hold MAX_STREAMS and at least the five bits that are reported
  localparam int CNT_W = ($clog2(MAX_STREAMS + 1) > 5) ? $clog2(MAX_STREAMS + 1) : 5;

  localparam int QUEUE_DEPTH = 4;  // power of two
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam int HDR_BYTES = 12;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int ENT_STORED = 4;  // last entry byte is used straight from input

  localparam logic [7:0] PMT_TABLE_ID = 8'h02;
  localparam logic [12:0] HDR_LAST_POS = 13'd11;
  localparam logic [11:0] MIN_SEC_LEN = 12'd10;
  localparam logic [2:0] ENT_LAST_IDX = 3'd4;

  typedef enum logic [2:0] {
    REC_HEADER      = 3'd0,
    REC_ENTRY       = 3'd1,
    REC_NOT_PMT     = 3'd2,
    REC_TABLE_FULL  = 3'd3,
    REC_SECTION_END = 3'd4
  } record_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_SEEK,
    PH_ENTRY
  } phase_t;

  typedef enum logic [1:0] {
    ITEM_DATA,
    ITEM_START_PMT,
    ITEM_START_OTHER
  } item_kind_t;

  typedef struct packed {
    logic [7:0] data;
    item_kind_t kind;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

>>> hdl/pmt_section_parser.sv
// ----------------------------------------------------------------------------
// pmt_section_parser
// Program map section parser, one section byte per transaction.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless the output stalls, no gaps between sections.
// A byte goes through a classifier and a four-entry queue into the parser,
// which handles one byte per cycle and loads at most one record per byte
// into the output register; a stalled output fills the queue, and in_ready
// drops only when the queue is full. A byte is queued, and its record is
// then registered in the output register. Records: header after byte 11,
// one per stream entry, not-a-program-map on a start byte whose table id
// is not 0x02, table full past MAX_STREAMS entries, section end at last byte.
// ----------------------------------------------------------------------------
module pmt_section_parser import pmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  section_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  record_kind,
  output logic [15:0] number_field,
  output logic [12:0] pid_field,
  output logic [11:0] length_field,
  output logic [11:0] sec_length,
  output logic [4:0]  version_number,
  output logic        current_next,
  output logic [7:0]  sec_number,
  output logic [7:0]  last_sec_number,
  output logic        syntax_indicator,
  output logic [4:0]  entry_count
);

  item_t         front_item;
  item_t         q_head;
  queue_status_t q_stat;
  logic          back_pop;
  logic          q_push;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  pmt_front u_front (
    .section_byte  (section_byte),
    .section_start (section_start),
    .item          (front_item)
  );

  pmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .pop       (back_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  pmt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_stat           (q_stat),
    .head             (q_head),
    .pop              (back_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .record_kind      (record_kind),
    .number_field     (number_field),
    .pid_field        (pid_field),
    .length_field     (length_field),
    .sec_length       (sec_length),
    .version_number   (version_number),
    .current_next     (current_next),
    .sec_number       (sec_number),
    .last_sec_number  (last_sec_number),
    .syntax_indicator (syntax_indicator),
    .entry_count      (entry_count)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    back_pop |-> q_stat.valid)
    else $error("parser popped an empty queue");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !back_pop)
    else $error("parser consumed a byte while the output was stalled");

  a_not_pmt_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == REC_NOT_PMT |->
      number_field == '0 && pid_field == '0 && sec_length == '0 &&
      entry_count == '0)
    else $error("not-a-program-map record carries field data");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == REC_HEADER |-> entry_count == '0)
    else $error("header record with nonzero entry count");

endmodule

>>> hdl/pmt_front.sv
// ----------------------------------------------------------------------------
// pmt_front
// Classifies each incoming byte: plain data, start of a program map section,
// or start of some other table.
// ----------------------------------------------------------------------------
module pmt_front import pmt_pkg::*; (
  input  logic [7:0] section_byte,
  input  logic       section_start,
  output item_t      item
);

  always_comb begin
    item.data = section_byte;
    if (!section_start) begin
      item.kind = ITEM_DATA;
    end else if (section_byte == PMT_TABLE_ID) begin
      item.kind = ITEM_START_PMT;
    end else begin
      item.kind = ITEM_START_OTHER;
    end
  end

endmodule

>>> hdl/pmt_queue.sv
// ----------------------------------------------------------------------------
// pmt_queue
// Short FIFO of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
module pmt_queue import pmt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         push_item,
  input  logic          pop,
  output item_t         head,
  output queue_status_t status
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.valid = (count != '0);
  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hdl/pmt_back.sv
// ----------------------------------------------------------------------------
// pmt_back
// Section parser: walks header, program info, stream entries and descriptors
// one byte per cycle when not stalled; loads records into the output register.
// ----------------------------------------------------------------------------
module pmt_back import pmt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_stat,
  input  item_t         head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    record_kind,
  output logic [15:0]   number_field,
  output logic [12:0]   pid_field,
  output logic [11:0]   length_field,
  output logic [11:0]   sec_length,
  output logic [4:0]    version_number,
  output logic          current_next,
  output logic [7:0]    sec_number,
  output logic [7:0]    last_sec_number,
  output logic          syntax_indicator,
  output logic [4:0]    entry_count
);

  phase_t           phase;
  phase_t           phase_next;
  logic [12:0]      byte_position;
  logic [11:0]      skip_remaining;
  logic [CNT_W-1:0] stream_count;
  logic [2:0]       entry_byte_index;
  logic [7:0]       hdr [HDR_BYTES];
  logic [7:0]       ent [ENT_STORED];

  logic [7:0]  b;
  logic [11:0] sec_len;
  logic [11:0] pil;
  logic [11:0] esl;
  logic [11:0] skip_dec;
  logic        end_hit;
  logic        seek_ok;
  logic        tbl_full;
  logic        hdr_done;
  logic        ent_done;

  logic             rec_fire;
  record_kind_t     rec_kind;
  logic [15:0]      rec_num;
  logic [12:0]      rec_pid;
  logic [11:0]      rec_len;
  logic             rec_with_hdr;
  logic [CNT_W-1:0] rec_count;

  record_kind_t out_kind;

  assign pop      = q_stat.valid && (!out_valid || out_ready);
  assign b        = head.data;
  assign sec_len  = {hdr[1][3:0], hdr[2]};
  assign pil      = {hdr[10][3:0], b};
  assign esl      = {ent[3][3:0], b};
  assign skip_dec = skip_remaining - 12'd1;
  assign end_hit  = (byte_position == ({1'b0, sec_len} + 13'd2));
  assign seek_ok  = (({1'b0, byte_position} + 14'd1) < {2'b00, sec_len});
  assign tbl_full = (stream_count >= CNT_W'(MAX_STREAMS));
  assign hdr_done = (byte_position >= HDR_LAST_POS);
  assign ent_done = (entry_byte_index == ENT_LAST_IDX);

  // next phase
  always_comb begin
    phase_next = phase;
    if (pop) begin
      if (head.kind == ITEM_START_PMT) begin
        phase_next = PH_HEADER;
      end else if (head.kind == ITEM_START_OTHER) begin
        phase_next = PH_IDLE;
      end else begin
        unique case (phase)
          PH_IDLE: phase_next = PH_IDLE;
          PH_HEADER: begin
            if (hdr_done) begin
              if (sec_len < MIN_SEC_LEN) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next = (pil != '0) ? PH_SKIP : PH_SEEK;
              end
            end
          end
          PH_SKIP: begin
            if (end_hit) begin
              phase_next = PH_IDLE;
            end else if (skip_dec == '0) begin
              phase_next = PH_SEEK;
            end
          end
          PH_SEEK: begin
            if (end_hit) begin
              phase_next = PH_IDLE;
            end else if (seek_ok) begin
              phase_next = tbl_full ? PH_IDLE : PH_ENTRY;
            end
          end
          PH_ENTRY: begin
            if (end_hit) begin
              phase_next = PH_IDLE;
            end else if (ent_done) begin
              phase_next = (esl != '0) ? PH_SKIP : PH_SEEK;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // record generation
  always_comb begin
    rec_fire     = 1'b0;
    rec_kind     = REC_HEADER;
    rec_num      = '0;
    rec_pid      = '0;
    rec_len      = '0;
    rec_with_hdr = 1'b1;
    rec_count    = '0;
    if (pop) begin
      if (head.kind == ITEM_START_OTHER) begin
        rec_fire     = 1'b1;
        rec_kind     = REC_NOT_PMT;
        rec_with_hdr = 1'b0;
      end else if (head.kind == ITEM_DATA) begin
        unique case (phase) inside
          PH_IDLE: rec_fire = 1'b0;
          PH_HEADER: begin
            if (hdr_done) begin
              rec_fire = 1'b1;
              rec_kind = REC_HEADER;
              rec_num  = {hdr[3], hdr[4]};
              rec_pid  = {hdr[8][4:0], hdr[9]};
              rec_len  = pil;
            end
          end
          PH_SKIP, PH_SEEK, PH_ENTRY: begin
            if (end_hit) begin
              rec_fire  = 1'b1;
              rec_kind  = REC_SECTION_END;
              rec_count = stream_count;
            end else if (phase == PH_SEEK && seek_ok && tbl_full) begin
              rec_fire  = 1'b1;
              rec_kind  = REC_TABLE_FULL;
              rec_count = stream_count;
            end else if (phase == PH_ENTRY && ent_done) begin
              rec_fire  = 1'b1;
              rec_kind  = REC_ENTRY;
              rec_num   = {8'h00, ent[0]};
              rec_pid   = {ent[1][4:0], ent[2]};
              rec_len   = esl;
              rec_count = stream_count + 1'b1;
            end
          end
          default: rec_fire = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_position    <= '0;
      skip_remaining   <= '0;
      stream_count     <= '0;
      entry_byte_index <= '0;
    end else begin
      phase <= phase_next;
      if (pop) begin
        if (head.kind != ITEM_DATA) begin
          byte_position    <= 13'd1;
          skip_remaining   <= '0;
          stream_count     <= '0;
          entry_byte_index <= '0;
        end else if (phase != PH_IDLE) begin
          byte_position <= byte_position + 13'd1;
          if (phase == PH_HEADER) begin
            if (hdr_done) begin
              skip_remaining <= pil;
            end
          end else if (!end_hit) begin
            if (phase == PH_SKIP) begin
              skip_remaining <= skip_dec;
            end else if (phase == PH_SEEK) begin
              if (seek_ok && !tbl_full) begin
                entry_byte_index <= 3'd1;
              end
            end else if (phase == PH_ENTRY) begin
              if (ent_done) begin
                entry_byte_index <= '0;
                stream_count     <= stream_count + 1'b1;
                skip_remaining   <= esl;
              end else begin
                entry_byte_index <= entry_byte_index + 3'd1;
              end
            end
          end
        end
      end
    end
  end

  // header and entry byte stores
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == ITEM_START_PMT) begin
        hdr[0] <= b;
      end else if (head.kind == ITEM_DATA) begin
        if (phase == PH_HEADER && byte_position < 13'(HDR_BYTES)) begin
          hdr[byte_position[HDR_IDX_W-1:0]] <= b;
        end
        if (!end_hit) begin
          if (phase == PH_SEEK && seek_ok && !tbl_full) begin
            ent[0] <= b;
          end
          if (phase == PH_ENTRY && !ent_done) begin
            ent[entry_byte_index[1:0]] <= b;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && rec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && rec_fire) begin
      out_kind     <= rec_kind;
      number_field <= rec_num;
      pid_field    <= rec_pid;
      length_field <= rec_len;
      entry_count  <= rec_count[4:0];
      if (rec_with_hdr) begin
        sec_length       <= sec_len;
        version_number   <= hdr[5][5:1];
        current_next     <= hdr[5][0];
        sec_number       <= hdr[6];
        last_sec_number  <= hdr[7];
        syntax_indicator <= hdr[1][7];
      end else begin
        sec_length       <= '0;
        version_number   <= '0;
        current_next     <= 1'b0;
        sec_number       <= '0;
        last_sec_number  <= '0;
        syntax_indicator <= 1'b0;
      end
    end
  end

  assign record_kind = out_kind;

endmodule

>>> tb/sv/pmt_record_checker.sv
// ----------------------------------------------------------------------------
// pmt_record_checker
// Watches both channels of the section parser and checks every record.
// ----------------------------------------------------------------------------
// Each accepted section byte is run through a cycle-free parser model that
// keeps its own header, entry and skip state. A record it produces is queued
// and compared field by field with the next record taken from the block.
// The mismatch count and the number of records still outstanding go to the
// testbench top.
// ----------------------------------------------------------------------------
module pmt_record_checker import pmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  section_byte,
  input  logic        section_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  record_kind,
  input  logic [15:0] number_field,
  input  logic [12:0] pid_field,
  input  logic [11:0] length_field,
  input  logic [11:0] sec_length,
  input  logic [4:0]  version_number,
  input  logic        current_next,
  input  logic [7:0]  sec_number,
  input  logic [7:0]  last_sec_number,
  input  logic        syntax_indicator,
  input  logic [4:0]  entry_count,
  output int          fail_count,
  output int          pending_count
);

  localparam int ENTRY_BYTES = 5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] number;
    logic [12:0] pid;
    logic [11:0] length;
    logic [11:0] sec_len;
    logic [4:0]  version;
    logic        cur_next;
    logic [7:0]  sec_num;
    logic [7:0]  last_sec_num;
    logic        syntax;
    logic [4:0]  count;
  } pmt_record_t;

  pmt_record_t predicted_records[$];
  int          mismatches = 0;

  // parser model state
  logic [12:0] pos_q;
  phase_t      phase_q;
  logic [7:0]  hdr_q [HDR_BYTES];
  logic [7:0]  ent_q [ENTRY_BYTES];
  int          ent_idx_q;
  logic [11:0] skip_q;
  int          streams_q;

  function automatic int section_len();
    return int'({hdr_q[1][3:0], hdr_q[2]});
  endfunction

  function automatic pmt_record_t header_record(record_kind_t k, logic [15:0] num,
                                                logic [12:0] pid, logic [11:0] len,
                                                logic [4:0] cnt);
    pmt_record_t r;
    r.kind = k;
    r.number = num;
    r.pid = pid;
    r.length = len;
    r.sec_len = hdr_q[1][3:0] == 4'd0 && hdr_q[2] == 8'd0 ? 12'd0
                                                           : {hdr_q[1][3:0], hdr_q[2]};
    r.version = hdr_q[5][5:1];
    r.cur_next = hdr_q[5][0];
    r.sec_num = hdr_q[6];
    r.last_sec_num = hdr_q[7];
    r.syntax = hdr_q[1][7];
    r.count = cnt;
    return r;
  endfunction

  // advances the model by one byte; returns 1 when the byte yields a record
  function automatic bit parse_byte(input logic [7:0] b, input logic s,
                                    output pmt_record_t r);
    int          p;
    int          len;
    logic [11:0] pil;
    logic [12:0] pid;
    logic [11:0] esl;
    r = '0;
    if (s) begin
      pos_q = 13'd1;
      streams_q = 0;
      ent_idx_q = 0;
      skip_q = '0;
      if (b != PMT_TABLE_ID) begin
        phase_q = PH_IDLE;
        r.kind = REC_NOT_PMT;
        return 1'b1;
      end
      hdr_q[0] = b;
      phase_q = PH_HEADER;
      return 1'b0;
    end
    if (phase_q == PH_IDLE) return 1'b0;

    p = int'(pos_q);
    pos_q = pos_q + 13'd1;

    if (phase_q == PH_HEADER) begin
      if (p < HDR_BYTES) hdr_q[p[HDR_IDX_W-1:0]] = b;
      if (p >= HDR_LAST_POS) begin
        pil = {hdr_q[10][3:0], hdr_q[11]};
        skip_q = pil;
        phase_q = (pil != 0) ? PH_SKIP : PH_SEEK;
        // too short to hold anything past the header
        if (section_len() < MIN_SEC_LEN) phase_q = PH_IDLE;
        r = header_record(REC_HEADER, {hdr_q[3], hdr_q[4]}, {hdr_q[8][4:0], hdr_q[9]},
                          pil, 5'd0);
        return 1'b1;
      end
      return 1'b0;
    end

    len = section_len();
    // last section byte wins over whatever is in progress
    if (p == len + 2) begin
      phase_q = PH_IDLE;
      r = header_record(REC_SECTION_END, '0, '0, '0, streams_q[4:0]);
      return 1'b1;
    end

    case (phase_q)
      PH_SKIP: begin
        skip_q = skip_q - 12'd1;
        if (skip_q == 0) phase_q = PH_SEEK;
        return 1'b0;
      end
      PH_SEEK: begin
        if (p + 1 < len) begin
          if (streams_q >= MAX_STREAMS) begin
            phase_q = PH_IDLE;
            r = header_record(REC_TABLE_FULL, '0, '0, '0, streams_q[4:0]);
            return 1'b1;
          end
          ent_q[0] = b;
          ent_idx_q = 1;
          phase_q = PH_ENTRY;
        end
        return 1'b0;
      end
      PH_ENTRY: begin
        if (ent_idx_q < ENTRY_BYTES) ent_q[ent_idx_q[2:0]] = b;
        ent_idx_q++;
        if (ent_idx_q >= ENTRY_BYTES) begin
          pid = {ent_q[1][4:0], ent_q[2]};
          esl = {ent_q[3][3:0], ent_q[4]};
          ent_idx_q = 0;
          if (streams_q < 255) streams_q++;
          skip_q = esl;
          phase_q = (esl != 0) ? PH_SKIP : PH_SEEK;
          r = header_record(REC_ENTRY, {8'h00, ent_q[0]}, pid, esl, streams_q[4:0]);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        phase_q = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic int compare_record(pmt_record_t want, pmt_record_t got);
    int n;
    n = 0;
    n += check_field("record_kind", 16'(want.kind), 16'(got.kind));
    n += check_field("number_field", want.number, got.number);
    n += check_field("pid_field", 16'(want.pid), 16'(got.pid));
    n += check_field("length_field", 16'(want.length), 16'(got.length));
    n += check_field("sec_length", 16'(want.sec_len), 16'(got.sec_len));
    n += check_field("version_number", 16'(want.version), 16'(got.version));
    n += check_field("current_next", 16'(want.cur_next), 16'(got.cur_next));
    n += check_field("sec_number", 16'(want.sec_num), 16'(got.sec_num));
    n += check_field("last_sec_number", 16'(want.last_sec_num), 16'(got.last_sec_num));
    n += check_field("syntax_indicator", 16'(want.syntax), 16'(got.syntax));
    n += check_field("entry_count", 16'(want.count), 16'(got.count));
    return (n != 0) ? 1 : 0;
  endfunction

  always @(posedge clk) begin : monitor
    pmt_record_t want;
    pmt_record_t got;
    pmt_record_t pred;
    if (rst) begin
      pos_q = '0;
      phase_q = PH_IDLE;
      for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] = '0;
      for (int i = 0; i < ENTRY_BYTES; i++) ent_q[i] = '0;
      ent_idx_q = 0;
      skip_q = '0;
      streams_q = 0;
      predicted_records.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(section_byte, section_start, pred)) predicted_records.push_back(pred);
      end
      if (out_valid && out_ready) begin
        got.kind = record_kind;
        got.number = number_field;
        got.pid = pid_field;
        got.length = length_field;
        got.sec_len = sec_length;
        got.version = version_number;
        got.cur_next = current_next;
        got.sec_num = sec_number;
        got.last_sec_num = last_sec_number;
        got.syntax = syntax_indicator;
        got.count = entry_count;
        if (predicted_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0d",
                   $time, record_kind);
          mismatches++;
        end else begin
          want = predicted_records.pop_front();
          mismatches += compare_record(want, got);
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= predicted_records.size();
  end

endmodule

>>> tb/sv/pmt_section_parser_tb.sv
// ----------------------------------------------------------------------------
// pmt_section_parser_tb
// Testbench top for the program map section parser.
// ----------------------------------------------------------------------------
// Sends a short directed byte sequence, then random sections: mostly well
// formed with random content, the rest truncated, with bad lengths, or plain
// noise. Handshake gaps change over three phases. Checking is done by
// pmt_record_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module pmt_section_parser_tb import pmt_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES = 450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  section_byte = 8'h00;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  record_kind;
  logic [15:0] number_field;
  logic [12:0] pid_field;
  logic [11:0] length_field;
  logic [11:0] sec_length;
  logic [4:0]  version_number;
  logic        current_next;
  logic [7:0]  sec_number;
  logic [7:0]  last_sec_number;
  logic        syntax_indicator;
  logic [4:0]  entry_count;

  int fail_count;
  int pending_count;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  pmt_section_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .section_byte(section_byte), .section_start(section_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .number_field(number_field), .pid_field(pid_field),
    .length_field(length_field), .sec_length(sec_length),
    .version_number(version_number), .current_next(current_next),
    .sec_number(sec_number), .last_sec_number(last_sec_number),
    .syntax_indicator(syntax_indicator), .entry_count(entry_count)
  );

  pmt_record_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .section_byte(section_byte), .section_start(section_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .number_field(number_field), .pid_field(pid_field),
    .length_field(length_field), .sec_length(sec_length),
    .version_number(version_number), .current_next(current_next),
    .sec_number(sec_number), .last_sec_number(last_sec_number),
    .syntax_indicator(syntax_indicator), .entry_count(entry_count),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  // ends the run when no transaction happens on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    section_byte <= b;
    section_start <= s;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold the input off until every predicted record has come out
  task automatic drain_records();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_section();
    logic [7:0]  sec[$];
    int          esls[$];
    int          mode;
    int          nstr;
    int          pil;
    int          esl;
    int          total;
    int          cut;
    logic [11:0] sl;
    logic [11:0] pl;
    logic [11:0] el;
    logic [7:0]  rb;
    mode = $urandom_range(0, 99);
    if (mode < 6) begin
      repeat ($urandom_range(1, 6)) begin
        rb = 8'($urandom);
        send_byte(rb, $urandom_range(0, 9) == 0);
      end
      return;
    end
    // a few sections run past the table limit
    nstr = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
    pil = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    total = 13 + pil;
    for (int i = 0; i < nstr; i++) begin
      esl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      esls.push_back(esl);
      total += 5 + esl;
    end
    sl = 12'(total);
    pl = 12'(pil);
    sec.push_back(PMT_TABLE_ID);
    rb = 8'($urandom);
    sec.push_back({rb[7:4], sl[11:8]});
    sec.push_back(sl[7:0]);
    repeat (7) begin
      rb = 8'($urandom);
      sec.push_back(rb);
    end
    rb = 8'($urandom);
    sec.push_back({rb[7:4], pl[11:8]});
    sec.push_back(pl[7:0]);
    repeat (pil) begin
      rb = 8'($urandom);
      sec.push_back(rb);
    end
    foreach (esls[i]) begin
      el = 12'(esls[i]);
      repeat (3) begin
        rb = 8'($urandom);
        sec.push_back(rb);
      end
      rb = 8'($urandom);
      sec.push_back({rb[7:4], el[11:8]});
      sec.push_back(el[7:0]);
      repeat (esls[i]) begin
        rb = 8'($urandom);
        sec.push_back(rb);
      end
    end
    repeat (4) begin
      rb = 8'($urandom);
      sec.push_back(rb);
    end
    if (mode < 22) begin
      case ($urandom_range(0, 3))
        0: begin
          // short or barely long enough section length
          sl = 12'($urandom_range(0, 14));
          sec[1][3:0] = sl[11:8];
          sec[2] = sl[7:0];
        end
        1: begin
          sec[1] = 8'($urandom);
          sec[2] = 8'($urandom);
        end
        2: begin
          sec[10] = 8'($urandom);
          sec[11] = 8'($urandom);
        end
        default: begin
          // cut short, the next start restarts the parser
          cut = $urandom_range(1, sec.size() - 1);
          while (sec.size() > cut) void'(sec.pop_back());
        end
      endcase
    end
    foreach (sec[i]) send_byte(sec[i], i == 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored idle byte, two foreign table ids, one small section
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(PMT_TABLE_ID, 1'b1);
    send_byte(8'hB0, 1'b0);      // syntax bit set, section length 18
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);      // program number
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);      // version 31, current
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);      // pcr pid, upper bits masked off
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);      // no program info
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);      // entry: type, pid, no descriptors
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (4) send_byte(8'hA5, 1'b0);  // crc
    drain_records();

    src_idle_pct = 32;
    snk_idle_pct = 46;
    while (bytes_sent < 24 + PHASE_BYTES) send_section();
    drain_records();

    src_idle_pct = 46;
    snk_idle_pct = 32;
    while (bytes_sent < 24 + 2 * PHASE_BYTES) send_section();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (bytes_sent < 24 + 3 * PHASE_BYTES) send_section();

    drain_records();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
